>>> rtl/rms_pkg.sv
package rms_pkg;

  localparam int unsigned DefMaxPairs = 1024;

  localparam logic [15:0] RotCosReset = 16'sd16384;
  localparam logic [23:0] GateReset   = 24'd307;

  typedef enum logic [2:0] {
    REG_ROT_COS  = 3'd0,
    REG_ROT_SIN  = 3'd1,
    REG_SHIFT_X  = 3'd2,
    REG_SHIFT_Y  = 3'd3,
    REG_GATE     = 3'd4
  } reg_idx_e;

  localparam logic [23:0] DistMax   = 24'hFFFFFF;
  localparam logic [13:0] ScoreCap  = 14'h3FFF;
  localparam logic [34:0] DsumCap   = {35{1'b1}};

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic rnd;
    logic sq;
    logic sqrt_init;
    logic sqrt_step;
    logic dist_ld;
    logic acc;
    logic div_init;
    logic div_step;
  } cmd_t;

  function automatic logic [3:0] score_of(input logic [23:0] d);
    logic [3:0] s;
    begin
      if      (d <= 24'd51)  s = 4'd10;
      else if (d <= 24'd204) s = 4'd8;
      else if (d <= 24'd307) s = 4'd6;
      else if (d <= 24'd512) s = 4'd4;
      else if (d <= 24'd819) s = 4'd2;
      else                   s = 4'd0;
      return s;
    end
  endfunction

endpackage

>>> rtl/rms_datapath.sv
module rms_datapath import rms_pkg::*; #(
  parameter int unsigned MaxPairs = DefMaxPairs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic [23:0] local_x_i,
  input  logic [23:0] local_y_i,
  input  logic [23:0] world_x_i,
  input  logic [23:0] world_y_i,
  input  logic        end_of_run_i,
  output logic [23:0] mapped_x_o,
  output logic [23:0] mapped_y_o,
  output logic [23:0] pair_distance_o,
  output logic [3:0]  pair_score_o,
  output logic [10:0] matched_count_o,
  output logic [13:0] total_score_o,
  output logic [23:0] mean_error_o,
  output logic        run_done_o
);

  localparam int unsigned CapI = (MaxPairs < 2047) ? MaxPairs : 2047;
  localparam logic [10:0] CountCap = 11'(CapI);

  logic signed [15:0] cos_q, sin_q;
  logic signed [23:0] shx_q, shy_q;
  logic [23:0] gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q  <= RotCosReset;
      sin_q  <= '0;
      shx_q  <= '0;
      shy_q  <= '0;
      gate_q <= GateReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROT_COS: cos_q  <= cfg_data_i[15:0];
        REG_ROT_SIN: sin_q  <= cfg_data_i[15:0];
        REG_SHIFT_X: shx_q  <= cfg_data_i;
        REG_SHIFT_Y: shy_q  <= cfg_data_i;
        REG_GATE:    gate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [23:0] lx_q, ly_q, wx_q, wy_q;
  logic               last_q;
  logic signed [39:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [26:0] mx_q, my_q;
  logic [52:0] sq_q;
  logic [52:0] rem_q, res_q;
  logic [53:0] n_q;
  logic [23:0] dist_q;
  logic [10:0] icnt_q, gcnt_q, icnt_use_q;
  logic [34:0] dsum_q, dsum_use_q, quo_q;
  logic [35:0] drem_q;
  logic [5:0]  didx_q;
  logic [13:0] ssum_q;
  logic [3:0]  score_q;

  logic signed [41:0] sx, sy;
  logic signed [41:0] rx, ry;
  logic signed [27:0] dx, dy;
  logic [26:0] adx, ady;

  always_comb begin
    sx = 42'(p0_q) - 42'(p1_q) + (42'(shx_q) <<< 14) + 42'sd8192;
    sy = 42'(p2_q) + 42'(p3_q) + (42'(shy_q) <<< 14) + 42'sd8192;
    rx = sx >>> 14;
    ry = sy >>> 14;
    dx = 28'(wx_q) - 28'(mx_q);
    dy = 28'(wy_q) - 28'(my_q);
    adx = dx[27] ? 27'(-dx) : 27'(dx);
    ady = dy[27] ? 27'(-dy) : 27'(dy);
  end

  // sqrt step: restoring, one result bit per cycle
  logic [53:0] trial;
  logic [53:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[51:0], n_q[53:52]};
    trial  = rem_sh - {res_q[51:0], 2'b01};
  end

  logic [35:0] dsh;
  always_comb dsh = {drem_q[34:0], dsum_use_q[6'd34 - didx_q]};

  logic [23:0] mapped_sat_x, mapped_sat_y;
  always_comb begin
    mapped_sat_x = (mx_q > 27'sd8388607) ? 24'h7FFFFF :
                   (mx_q < -27'sd8388608) ? 24'h800000 : mx_q[23:0];
    mapped_sat_y = (my_q > 27'sd8388607) ? 24'h7FFFFF :
                   (my_q < -27'sd8388608) ? 24'h800000 : my_q[23:0];
  end

  logic [35:0] dsum_add;
  always_comb dsum_add = {1'b0, dsum_q} + 36'(dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icnt_q <= '0;
      gcnt_q <= '0;
      dsum_q <= '0;
      ssum_q <= '0;
    end else if (cmd_i.acc) begin
      if (last_q) begin
        icnt_q <= '0;
        gcnt_q <= '0;
        dsum_q <= '0;
        ssum_q <= '0;
      end else begin
        icnt_q <= icnt_use_q;
        gcnt_q <= matched_count_o;
        dsum_q <= dsum_use_q;
        ssum_q <= total_score_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lx_q <= local_x_i; ly_q <= local_y_i;
      wx_q <= world_x_i; wy_q <= world_y_i;
      last_q <= end_of_run_i;
    end
    if (cmd_i.mul_a) begin
      p0_q <= lx_q * cos_q;
      p1_q <= ly_q * sin_q;
    end
    if (cmd_i.mul_b) begin
      p2_q <= lx_q * sin_q;
      p3_q <= ly_q * cos_q;
    end
    if (cmd_i.rnd) begin
      mx_q <= rx[26:0];
      my_q <= ry[26:0];
    end
    if (cmd_i.sq) sq_q <= 53'(adx * adx) + 53'(ady * ady);
    if (cmd_i.sqrt_init) begin
      n_q <= {1'b0, sq_q};
      rem_q <= '0;
      res_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      n_q <= {n_q[51:0], 2'b00};
      if (!trial[53]) begin
        rem_q <= trial[52:0];
        res_q <= {res_q[51:0], 1'b1};
      end else begin
        rem_q <= rem_sh[52:0];
        res_q <= {res_q[51:0], 1'b0};
      end
    end
    if (cmd_i.dist_ld) begin
      dist_q  <= (res_q > 53'(DistMax)) ? DistMax : res_q[23:0];
    end
    if (cmd_i.div_init) begin
      score_q <= score_of(dist_q);
      icnt_use_q <= (icnt_q < CountCap) ? icnt_q + 11'd1 : icnt_q;
      if (dist_q < gate_q) begin
        matched_count_o <= (gcnt_q < CountCap) ? gcnt_q + 11'd1 : gcnt_q;
        dsum_use_q <= dsum_add[35] ? DsumCap : dsum_add[34:0];
      end else begin
        matched_count_o <= gcnt_q;
        dsum_use_q <= dsum_q;
      end
      total_score_o <= ({1'b0, ssum_q} + 15'(score_of(dist_q)) > 15'(ScoreCap)) ?
                       ScoreCap : 14'(ssum_q + 14'(score_of(dist_q)));
      drem_q <= '0;
      quo_q  <= '0;
      didx_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (dsh >= 36'(icnt_use_q)) begin
        drem_q <= dsh - 36'(icnt_use_q);
        quo_q  <= {quo_q[33:0], 1'b1};
      end else begin
        drem_q <= dsh;
        quo_q  <= {quo_q[33:0], 1'b0};
      end
      didx_q <= didx_q + 6'd1;
    end
  end

  assign mapped_x_o      = mapped_sat_x;
  assign mapped_y_o      = mapped_sat_y;
  assign pair_distance_o = dist_q;
  assign pair_score_o    = score_q;
  assign run_done_o      = last_q;
  assign mean_error_o    = (!last_q || icnt_use_q == '0) ? '0 :
                           ((quo_q > 35'(DistMax)) ? DistMax : quo_q[23:0]);

endmodule

>>> rtl/rms_ctrl.sv
module rms_ctrl import rms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULA, ST_MULB, ST_RND, ST_SQ, ST_SQI, ST_SQRT, ST_ACC,
    ST_DIVI, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;
  logic [5:0] cnt_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load      = in_valid_i;
      ST_MULA: cmd_o.mul_a     = 1'b1;
      ST_MULB: cmd_o.mul_b     = 1'b1;
      ST_RND:  cmd_o.rnd       = 1'b1;
      ST_SQ:   cmd_o.sq        = 1'b1;
      ST_SQI:  cmd_o.sqrt_init = 1'b1;
      ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_ACC:  cmd_o.dist_ld   = 1'b1;
      ST_DIVI: cmd_o.div_init  = 1'b1;
      ST_DIV:  cmd_o.div_step  = 1'b1;
      ST_OUT:  cmd_o.acc       = out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_MULA;
        ST_MULA: state_q <= ST_MULB;
        ST_MULB: state_q <= ST_RND;
        ST_RND:  state_q <= ST_SQ;
        ST_SQ:   state_q <= ST_SQI;
        ST_SQI: begin
          state_q <= ST_SQRT;
          cnt_q   <= '0;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd26) state_q <= ST_ACC;
        end
        ST_ACC:  state_q <= ST_DIVI;
        ST_DIVI: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd34) state_q <= ST_OUT;
        end
        ST_OUT:  if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sqrt_step, cmd_o.div_step, cmd_o.load})) else $error("cmd clash");

endmodule

>>> rtl/rigid_match_error_scorer.sv
// Rigid match error scorer: one point pair per beat. The local point is
// rotated (Q1.14) and shifted, the distance to the world point is taken
// with a bit-serial square root and the running totals are updated; on
// end_of_run the mean error comes from a bit-serial divider and totals clear.
// One item at a time; the 27 square-root steps and 35 divider steps
// dominate the time per item. Registers must be written only while idle;
// the block itself does not enforce this.
module rigid_match_error_scorer import rms_pkg::*; #(
  parameter int unsigned MaxPairs = DefMaxPairs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] local_x_i,
  input  logic [23:0] local_y_i,
  input  logic [23:0] world_x_i,
  input  logic [23:0] world_y_i,
  input  logic        end_of_run_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] mapped_x_o,
  output logic [23:0] mapped_y_o,
  output logic [23:0] pair_distance_o,
  output logic [3:0]  pair_score_o,
  output logic [10:0] matched_count_o,
  output logic [13:0] total_score_o,
  output logic [23:0] mean_error_o,
  output logic        run_done_o
);

  cmd_t cmd;

  rms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  rms_datapath #(.MaxPairs(MaxPairs)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .local_x_i, .local_y_i, .world_x_i, .world_y_i, .end_of_run_i,
    .mapped_x_o, .mapped_y_o, .pair_distance_o, .pair_score_o,
    .matched_count_o, .total_score_o, .mean_error_o, .run_done_o
  );

endmodule

>>> tb/rigid_match_error_scorer_tb.sv
`timescale 1ns / 1ps

module rigid_match_error_scorer_tb;
  import rms_pkg::*;

  localparam int unsigned CountCap = (DefMaxPairs < 2047) ? DefMaxPairs : 2047;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [23:0] mx;
    logic [23:0] my;
    logic [23:0] pdist;
    logic [3:0]  score;
    logic [10:0] gated;
    logic [13:0] total;
    logic [23:0] mean;
    logic        done;
  } pair_result_t;

  class error_scoreboard;
    logic signed [63:0] rcos, rsin, sx, sy;
    logic [23:0] gate;
    int unsigned n_items, n_gated, score_acc;
    logic [63:0] dsum;
    pair_result_t pending[$];
    int unsigned mismatches;

    function new();
      rcos = 16384; rsin = 0; sx = 0; sy = 0; gate = 24'd307;
      n_items = 0; n_gated = 0; dsum = 0; score_acc = 0; mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [23:0] v);
      case (idx)
        REG_ROT_COS: rcos = $signed(v[15:0]);
        REG_ROT_SIN: rsin = $signed(v[15:0]);
        REG_SHIFT_X: sx = $signed(v);
        REG_SHIFT_Y: sy = $signed(v);
        REG_GATE:    gate = v;
        default: ;
      endcase
    endfunction

    function logic signed [63:0] round14(logic signed [63:0] v);
      return (v + 64'sd8192) >>> 14;
    endfunction

    function logic [23:0] clamp24(logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
    endfunction

    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_pair(logic [23:0] lx, logic [23:0] ly, logic [23:0] wx,
                            logic [23:0] wy, logic last);
      logic signed [63:0] x, y, mxf, myf, dx, dy;
      logic [63:0] d, m;
      pair_result_t r;
      x = $signed(lx); y = $signed(ly);
      mxf = round14(x * rcos - y * rsin + sx * 64'sd16384);
      myf = round14(x * rsin + y * rcos + sy * 64'sd16384);
      dx = $signed(wx) - mxf; dy = $signed(wy) - myf;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = root_floor(dx * dx + dy * dy);
      if (d > 64'd16777215) d = 64'd16777215;
      r.mx = clamp24(mxf);
      r.my = clamp24(myf);
      r.pdist = d[23:0];
      r.score = score_of(r.pdist);
      if (n_items < CountCap) n_items++;
      if (r.pdist < gate) begin
        if (n_gated < CountCap) n_gated++;
        dsum = dsum + r.pdist;
        if (dsum > DsumCap) dsum = DsumCap;
      end
      score_acc = score_acc + r.score;
      if (score_acc > ScoreCap) score_acc = ScoreCap;
      m = 0;
      if (last && n_items != 0) begin
        m = dsum / n_items;
        if (m > 64'd16777215) m = 64'd16777215;
      end
      r.gated = n_gated[10:0];
      r.total = score_acc[13:0];
      r.mean = m[23:0];
      r.done = last;
      pending.insert(pending.size(), r);
      if (last) begin
        n_items = 0; n_gated = 0; dsum = 0; score_acc = 0;
      end
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp mx=%h my=%h d=%h s=%0d g=%0d t=%0d m=%h done=%b",
                   e.mx, e.my, e.pdist, e.score, e.gated, e.total, e.mean, e.done);
          $display("          got mx=%h my=%h d=%h s=%0d g=%0d t=%0d m=%h done=%b",
                   got.mx, got.my, got.pdist, got.score, got.gated, got.total,
                   got.mean, got.done);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [23:0] local_x_i = '0, local_y_i = '0, world_x_i = '0, world_y_i = '0;
  logic end_of_run_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [23:0] mapped_x_o, mapped_y_o, pair_distance_o, mean_error_o;
  logic [3:0] pair_score_o;
  logic [10:0] matched_count_o;
  logic [13:0] total_score_o;
  logic run_done_o;

  error_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;
  bit hold_off = 1'b0;

  always #10 clk_i = ~clk_i;

  rigid_match_error_scorer u_dut (.*);

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      sb.note_pair(local_x_i, local_y_i, world_x_i, world_y_i, end_of_run_i);
    if (out_valid_o && out_ready_i)
      sb.check_result({mapped_x_o, mapped_y_o, pair_distance_o, pair_score_o,
                       matched_count_o, total_score_o, mean_error_o, run_done_o});
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (quiet_receiver) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 10);
  end

  task automatic write_reg(reg_idx_e idx, logic [23:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pair(logic [23:0] lx, logic [23:0] ly, logic [23:0] wx,
                           logic [23:0] wy, logic last);
    int unsigned gap;
    gap = 0;
    while (!quiet_sender && $urandom_range(99) < 10) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    local_x_i <= lx; local_y_i <= ly;
    world_x_i <= wx; world_y_i <= wy;
    end_of_run_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(2000) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_run(int unsigned n);
    logic [23:0] lx, ly, wx, wy;
    for (int unsigned i = 0; i < n; i++) begin
      lx = ($urandom_range(3) == 0) ? pick24() : 24'($urandom_range(40000) - 20000);
      ly = ($urandom_range(3) == 0) ? pick24() : 24'($urandom_range(40000) - 20000);
      // world point near the local one most of the time
      wx = lx + 24'($urandom_range(1200) - 600);
      wy = ly + 24'($urandom_range(1200) - 600);
      if ($urandom_range(7) == 0) wx = pick24();
      if ($urandom_range(7) == 0) wy = pick24();
      send_pair(lx, ly, wx, wy, (i == n - 1) || ($urandom_range(29) == 0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b0);
    send_pair(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_pair(24'd0, 24'd0, 24'd51, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd52, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd0, 24'd204, 1'b0);
    send_pair(24'd0, 24'd0, 24'd306, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd307, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd300, 24'd400, 1'b0);
    send_pair(24'd0, 24'd0, 24'd819, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd820, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    send_pair(24'd5, 24'd5, 24'd5, 24'd5, 1'b1);
    drain();

    write_reg(REG_ROT_COS, 24'h00C000);
    write_reg(REG_ROT_SIN, 24'h004000);
    write_reg(REG_SHIFT_X, 24'h7FFFFF);
    write_reg(REG_SHIFT_Y, 24'h800000);
    write_reg(REG_GATE, 24'hFFFFFF);
    send_pair(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b0);
    send_pair(24'h000001, 24'h000003, 24'h7FFFFF, 24'h800000, 1'b1);
    drain();

    // long run with no gaps
    write_reg(REG_ROT_COS, 24'd16384);
    write_reg(REG_ROT_SIN, 24'd0);
    write_reg(REG_SHIFT_X, 24'd0);
    write_reg(REG_SHIFT_Y, 24'd0);
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    for (int i = 0; i < 100; i++) send_pair(24'd10, 24'd20, 24'd10, 24'd20, i == 99);
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    drain();

    // receiver hold-off with the sender still pushing
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_run(20);
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ROT_COS, 24'd11585);
          write_reg(REG_ROT_SIN, 24'd11585);
          write_reg(REG_SHIFT_X, 24'd1000);
          write_reg(REG_SHIFT_Y, 24'hFFFC18);
          write_reg(REG_GATE, 24'd307);
        end
        1: begin
          write_reg(REG_ROT_COS, 24'h00C000);
          write_reg(REG_ROT_SIN, 24'd0);
          write_reg(REG_SHIFT_X, 24'd0);
          write_reg(REG_SHIFT_Y, 24'd0);
          write_reg(REG_GATE, 24'd0);
        end
        2: begin
          write_reg(REG_ROT_COS, 24'($urandom));
          write_reg(REG_ROT_SIN, 24'($urandom));
          write_reg(REG_SHIFT_X, 24'($urandom));
          write_reg(REG_SHIFT_Y, 24'($urandom));
          write_reg(REG_GATE, 24'($urandom_range(1000)));
        end
        default: begin
          write_reg(REG_ROT_COS, 24'd16384);
          write_reg(REG_ROT_SIN, 24'd0);
          write_reg(REG_SHIFT_X, 24'd0);
          write_reg(REG_SHIFT_Y, 24'd0);
          write_reg(REG_GATE, 24'd600);
        end
      endcase
      quiet_sender = (phase == 3);
      quiet_receiver = (phase == 3);
      random_run(115);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rms_pkg.sv
rtl/rms_datapath.sv
rtl/rms_ctrl.sv
rtl/rigid_match_error_scorer.sv
tb/rigid_match_error_scorer_tb.sv
